[hdl/mlp_relu_inference_top_defines.svh]
// assertion macros for the mlp inference block
`ifndef MLP_RELU_INFERENCE_TOP_DEFINES_SVH
`define MLP_RELU_INFERENCE_TOP_DEFINES_SVH

// same-cycle implication
`define MLP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mlp check failed");

// next-cycle implication
`define MLP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mlp check failed");

`endif

[hdl/mlp_pkg.sv]
// shared types, constants and arithmetic helpers for the mlp inference block
package mlp_pkg;

  localparam int DEF_N_IN = 8;
  localparam int DEF_N_HID = 16;
  localparam int DEF_N_OUT = 4;
  localparam int DEF_PARAM_DEPTH = 2048;
  localparam int MAX_EMIT = 4;
  localparam int ADDR_W = 11;
  localparam int DATA_W = 32;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [2:0] LAYER_IN = 3'd0;
  localparam logic [2:0] LAYER_OUT = 3'd5;

  localparam logic signed [63:0] Q_ONE = 64'sd65536;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SC_DIFF,
    OP_SC_MUL,
    OP_SC_WR,
    OP_ACC_CLR,
    OP_MAC_MUL,
    OP_MAC_ACC,
    OP_B_ACC,
    OP_N_WR,
    OP_Y_U,
    OP_Y_LO,
    OP_Y_SUB,
    OP_Y_MUL,
    OP_Y_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] layer;
    logic       out_last;
  } dp_cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    logic signed [63:0] r;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else r = s[63:0];
    return r;
  endfunction

endpackage

[hdl/mlp_if.sv]
// valid/ready channel interfaces for input and result words
interface mlp_in_if;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [10:0]               address;
  logic signed [31:0]        value;
  logic                      last;
  modport source (output valid, command, address, value, last, input ready);
  modport sink (input valid, command, address, value, last, output ready);
endinterface

interface mlp_out_if;
  logic                      valid;
  logic                      ready;
  logic signed [31:0]        result_value;
  logic [1:0]                output_index;
  logic                      last_output;
  modport source (output valid, result_value, output_index, last_output, input ready);
  modport sink (input valid, result_value, output_index, last_output, output ready);
endinterface

[hdl/mlp_datapath.sv]
// mlp datapath: memories, multipliers (one shared by scaling and mac), accumulator and output register
module mlp_datapath #(
  parameter int N_IN = mlp_pkg::DEF_N_IN,
  parameter int N_HID = mlp_pkg::DEF_N_HID,
  parameter int PARAM_DEPTH = mlp_pkg::DEF_PARAM_DEPTH,
  parameter int AW = $clog2(PARAM_DEPTH),
  parameter int CW = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                in_take,
  input  logic                in_cmd,
  input  logic [10:0]         in_addr,
  input  logic signed [31:0]  in_value,
  input  mlp_pkg::dp_cmd_t    cmd,
  input  logic [AW-1:0]       p_raddr,
  input  logic [CW-1:0]       i,
  input  logic [CW-1:0]       j,
  output logic signed [31:0]  result_value,
  output logic [1:0]          output_index,
  output logic                last_output
);

  localparam int IW = (N_IN > 1) ? $clog2(N_IN) : 1;
  localparam int HW = (N_HID > 1) ? $clog2(N_HID) : 1;

  logic signed [31:0] pmem [PARAM_DEPTH];
  logic signed [31:0] samp [N_IN];
  logic signed [31:0] xbuf [N_IN];
  logic signed [31:0] act_a [N_HID];
  logic signed [31:0] act_b [N_HID];

  logic signed [31:0] pdata, sdata, xdata, adata, bdata;
  logic signed [31:0] sreg, diff, o, u, lo;
  logic signed [32:0] ydiff;
  logic signed [63:0] prod, acc;
  logic signed [64:0] yprod;
  logic               scale_enable;

  logic [31:0]        a32;
  logic signed [31:0] src, s_val, m_val, v_val, r_val;
  logic               wr_a, wr_b;

  always_comb begin
    a32 = 32'(in_addr);
    case (cmd.layer)
      mlp_pkg::LAYER_IN: src = xdata;
      default: src = cmd.layer[0] ? adata : bdata;
    endcase
    s_val = scale_enable ? mlp_pkg::sat32(64'(prod >>> 16)) : sreg;
    m_val = mlp_pkg::sat32(64'(s_val) * 64'sd2 - mlp_pkg::Q_ONE);
    v_val = mlp_pkg::sat32(64'(acc >>> 16));
    r_val = scale_enable ? mlp_pkg::sat32(64'(yprod >>> 16) + 64'(lo)) : u;
    wr_a = (cmd.op == mlp_pkg::OP_N_WR) && !cmd.layer[0] && (cmd.layer != mlp_pkg::LAYER_OUT);
    wr_b = (cmd.op == mlp_pkg::OP_N_WR) && cmd.layer[0] && (cmd.layer != mlp_pkg::LAYER_OUT);
  end

  always_ff @(posedge clk) begin
    if (in_take && in_cmd == mlp_pkg::CMD_LOAD && a32 < 32'(PARAM_DEPTH)) begin
      pmem[a32[AW-1:0]] <= in_value;
    end
    pdata <= pmem[p_raddr];
  end

  always_ff @(posedge clk) begin
    if (in_take && in_cmd == mlp_pkg::CMD_SAMPLE && a32 < 32'(N_IN)) begin
      samp[a32[IW-1:0]] <= in_value;
    end
    sdata <= samp[i[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == mlp_pkg::OP_SC_WR) begin
      xbuf[i[IW-1:0]] <= m_val;
    end
    xdata <= xbuf[j[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr_a) begin
      act_a[i[HW-1:0]] <= (v_val < 0) ? 32'sd0 : v_val;
    end
    adata <= act_a[j[HW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      act_b[i[HW-1:0]] <= (v_val < 0) ? 32'sd0 : v_val;
    end
    bdata <= act_b[j[HW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_enable <= 1'b1;
      acc <= '0;
    end else begin
      if (cfg_we) scale_enable <= cfg_wdata;
      case (cmd.op)
        mlp_pkg::OP_ACC_CLR: acc <= '0;
        mlp_pkg::OP_MAC_ACC: acc <= mlp_pkg::sat_add64(acc, prod);
        mlp_pkg::OP_B_ACC: acc <= mlp_pkg::sat_add64(acc, 64'(pdata) * mlp_pkg::Q_ONE);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      mlp_pkg::OP_SC_DIFF: begin
        diff <= mlp_pkg::sat32(64'(sdata) - 64'(pdata));
        sreg <= sdata;
      end
      mlp_pkg::OP_SC_MUL: prod <= 64'(diff) * 64'(pdata);
      mlp_pkg::OP_MAC_MUL: prod <= 64'(src) * 64'(pdata);
      mlp_pkg::OP_N_WR: o <= v_val;
      mlp_pkg::OP_Y_U: u <= 32'((33'(o) + 33'sd65536) >>> 1);
      mlp_pkg::OP_Y_LO: lo <= pdata;
      mlp_pkg::OP_Y_SUB: ydiff <= 33'(pdata) - 33'(lo);
      mlp_pkg::OP_Y_MUL: yprod <= 65'(u) * 65'(ydiff);
      mlp_pkg::OP_Y_FIN: begin
        result_value <= r_val;
        output_index <= 2'(i);
        last_output <= cmd.out_last;
      end
      default: ;
    endcase
  end

endmodule

[hdl/mlp_ctrl.sv]
// mlp controller: sequencing of scaling, layers and output words
`include "mlp_relu_inference_top_defines.svh"

module mlp_ctrl #(
  parameter int N_IN = mlp_pkg::DEF_N_IN,
  parameter int N_HID = mlp_pkg::DEF_N_HID,
  parameter int N_OUT = mlp_pkg::DEF_N_OUT,
  parameter int PARAM_DEPTH = mlp_pkg::DEF_PARAM_DEPTH,
  parameter int AW = $clog2(PARAM_DEPTH),
  parameter int CW = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_cmd,
  input  logic              in_last,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output mlp_pkg::dp_cmd_t  cmd,
  output logic [AW-1:0]     p_raddr,
  output logic [CW-1:0]     i,
  output logic [CW-1:0]     j
);

  localparam int NEMIT = (N_OUT < mlp_pkg::MAX_EMIT) ? N_OUT : mlp_pkg::MAX_EMIT;
  localparam int OFS_XMIN = 0;
  localparam int OFS_XRCP = OFS_XMIN + N_IN;
  localparam int OFS_YMIN = OFS_XRCP + N_IN;
  localparam int OFS_YMAX = OFS_YMIN + N_OUT;
  localparam int OFS_IN_W = OFS_YMAX + N_OUT;
  localparam int OFS_IN_B = OFS_IN_W + N_HID * N_IN;
  localparam int OFS_HID = OFS_IN_B + N_HID;
  localparam int HID_SPAN = N_HID * N_HID + N_HID;
  localparam int OFS_OUT_W = OFS_HID + 4 * HID_SPAN;
  localparam int OFS_OUT_B = OFS_OUT_W + N_OUT * N_HID;

  typedef enum logic [4:0] {
    IDLE, SC_RD1, SC_RD2, SC_MUL, SC_WR, L_START, N_START, MAC_RD, MAC_MUL,
    MAC_ACC, B_RD, B_ACC, N_WR, Y_RD1, Y_RD2, Y_SUB, Y_MUL, Y_FIN, Y_WAIT
  } state_t;

  state_t         state;
  logic [2:0]     layer;
  logic [AW-1:0]  p0, p1, y0, y1;
  logic           out_last;
  logic [AW-1:0]  wb, bb;
  logic [CW-1:0]  fan_last, nd_last;
  mlp_pkg::dp_op_t op;

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    return (p == AW'(PARAM_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    case (layer)
      3'd0: begin
        wb = AW'(OFS_IN_W % PARAM_DEPTH);
        bb = AW'(OFS_IN_B % PARAM_DEPTH);
      end
      3'd1: begin
        wb = AW'(OFS_HID % PARAM_DEPTH);
        bb = AW'((OFS_HID + N_HID * N_HID) % PARAM_DEPTH);
      end
      3'd2: begin
        wb = AW'((OFS_HID + HID_SPAN) % PARAM_DEPTH);
        bb = AW'((OFS_HID + HID_SPAN + N_HID * N_HID) % PARAM_DEPTH);
      end
      3'd3: begin
        wb = AW'((OFS_HID + 2 * HID_SPAN) % PARAM_DEPTH);
        bb = AW'((OFS_HID + 2 * HID_SPAN + N_HID * N_HID) % PARAM_DEPTH);
      end
      3'd4: begin
        wb = AW'((OFS_HID + 3 * HID_SPAN) % PARAM_DEPTH);
        bb = AW'((OFS_HID + 3 * HID_SPAN + N_HID * N_HID) % PARAM_DEPTH);
      end
      default: begin
        wb = AW'(OFS_OUT_W % PARAM_DEPTH);
        bb = AW'(OFS_OUT_B % PARAM_DEPTH);
      end
    endcase
    fan_last = (layer == mlp_pkg::LAYER_IN) ? CW'(N_IN - 1) : CW'(N_HID - 1);
    nd_last = (layer == mlp_pkg::LAYER_OUT) ? CW'(NEMIT - 1) : CW'(N_HID - 1);
  end

  always_comb begin
    case (state)
      SC_RD2:  op = mlp_pkg::OP_SC_DIFF;
      SC_MUL:  op = mlp_pkg::OP_SC_MUL;
      SC_WR:   op = mlp_pkg::OP_SC_WR;
      N_START: op = mlp_pkg::OP_ACC_CLR;
      MAC_MUL: op = mlp_pkg::OP_MAC_MUL;
      MAC_ACC: op = mlp_pkg::OP_MAC_ACC;
      B_ACC:   op = mlp_pkg::OP_B_ACC;
      N_WR:    op = mlp_pkg::OP_N_WR;
      Y_RD1:   op = mlp_pkg::OP_Y_U;
      Y_RD2:   op = mlp_pkg::OP_Y_LO;
      Y_SUB:   op = mlp_pkg::OP_Y_SUB;
      Y_MUL:   op = mlp_pkg::OP_Y_MUL;
      Y_FIN:   op = mlp_pkg::OP_Y_FIN;
      default: op = mlp_pkg::OP_NONE;
    endcase
    case (state)
      SC_RD2, B_RD: p_raddr = p1;
      Y_RD1:        p_raddr = y0;
      Y_RD2:        p_raddr = y1;
      default:      p_raddr = p0;
    endcase
    cmd.op = op;
    cmd.layer = layer;
    cmd.out_last = (i == CW'(NEMIT - 1));
    in_ready = (state == IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      layer <= '0;
      i <= '0;
      j <= '0;
      p0 <= '0;
      p1 <= '0;
      y0 <= '0;
      y1 <= '0;
      out_valid <= 1'b0;
      out_last <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid && in_cmd == mlp_pkg::CMD_SAMPLE && in_last) begin
            p0 <= AW'(OFS_XMIN % PARAM_DEPTH);
            p1 <= AW'(OFS_XRCP % PARAM_DEPTH);
            i <= '0;
            state <= SC_RD1;
          end
        end
        SC_RD1: begin
          p0 <= inc(p0);
          state <= SC_RD2;
        end
        SC_RD2: begin
          p1 <= inc(p1);
          state <= SC_MUL;
        end
        SC_MUL: state <= SC_WR;
        SC_WR: begin
          if (i == CW'(N_IN - 1)) begin
            layer <= mlp_pkg::LAYER_IN;
            state <= L_START;
          end else begin
            i <= i + 1'b1;
            state <= SC_RD1;
          end
        end
        L_START: begin
          p0 <= wb;
          p1 <= bb;
          i <= '0;
          y0 <= AW'(OFS_YMIN % PARAM_DEPTH);
          y1 <= AW'(OFS_YMAX % PARAM_DEPTH);
          state <= N_START;
        end
        N_START: begin
          j <= '0;
          state <= MAC_RD;
        end
        MAC_RD: begin
          p0 <= inc(p0);
          state <= MAC_MUL;
        end
        MAC_MUL: state <= MAC_ACC;
        MAC_ACC: begin
          if (j == fan_last) begin
            state <= B_RD;
          end else begin
            j <= j + 1'b1;
            state <= MAC_RD;
          end
        end
        B_RD: begin
          p1 <= inc(p1);
          state <= B_ACC;
        end
        B_ACC: state <= N_WR;
        N_WR: begin
          if (layer == mlp_pkg::LAYER_OUT) begin
            state <= Y_RD1;
          end else if (i == nd_last) begin
            layer <= layer + 1'b1;
            state <= L_START;
          end else begin
            i <= i + 1'b1;
            state <= N_START;
          end
        end
        Y_RD1: state <= Y_RD2;
        Y_RD2: state <= Y_SUB;
        Y_SUB: state <= Y_MUL;
        Y_MUL: state <= Y_FIN;
        Y_FIN: begin
          out_valid <= 1'b1;
          out_last <= (i == CW'(NEMIT - 1));
          state <= Y_WAIT;
        end
        Y_WAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            y0 <= inc(y0);
            y1 <= inc(y1);
            if (out_last) begin
              state <= IDLE;
            end else begin
              i <= i + 1'b1;
              state <= N_START;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `MLP_ASSERT_IMP(a_no_take_while_out, clk, rst, out_valid, !in_ready)
  `MLP_ASSERT_NXT(a_start_busy, clk, rst, in_valid && in_ready && in_cmd == mlp_pkg::CMD_SAMPLE && in_last, !in_ready)
  `MLP_ASSERT_NXT(a_done_idle, clk, rst, out_valid && out_ready && out_last, in_ready && !out_valid)

endmodule

[hdl/mlp_relu_inference_top.sv]
// mlp relu inference top level: loads parameters, takes samples, emits outputs
// load words and non-final sample words are taken one per cycle while the controller is idle
// final sample word: starts scaling, the layers and the emission of min(N_OUT,4) results;
//   the controller stays busy until the last result is taken, so output stalls lengthen
//   the run; each product passes one shared mac through MAC_RD, MAC_MUL and MAC_ACC
// rst: controller idle, no result pending, scale_enable = 1, accumulator zero
// parameter and sample memories hold undefined data until written
module mlp_relu_inference_top #(
  parameter int N_IN = mlp_pkg::DEF_N_IN,
  parameter int N_HID = mlp_pkg::DEF_N_HID,
  parameter int N_OUT = mlp_pkg::DEF_N_OUT,
  parameter int PARAM_DEPTH = mlp_pkg::DEF_PARAM_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  mlp_in_if.sink      item,
  mlp_out_if.source   result
);

  localparam int AW = $clog2(PARAM_DEPTH);
  localparam int MX = (N_IN > N_HID) ? N_IN : N_HID;
  localparam int CW = (MX > 1) ? $clog2(MX) : 1;

  mlp_pkg::dp_cmd_t cmd;
  logic [AW-1:0]    p_raddr;
  logic [CW-1:0]    i, j;

  mlp_ctrl #(
    .N_IN(N_IN), .N_HID(N_HID), .N_OUT(N_OUT), .PARAM_DEPTH(PARAM_DEPTH),
    .AW(AW), .CW(CW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(item.valid),
    .in_cmd(item.command),
    .in_last(item.last),
    .in_ready(item.ready),
    .out_valid(result.valid),
    .out_ready(result.ready),
    .cmd(cmd),
    .p_raddr(p_raddr),
    .i(i),
    .j(j)
  );

  mlp_datapath #(
    .N_IN(N_IN), .N_HID(N_HID), .PARAM_DEPTH(PARAM_DEPTH), .AW(AW), .CW(CW)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_take(item.valid && item.ready),
    .in_cmd(item.command),
    .in_addr(item.address),
    .in_value(item.value),
    .cmd(cmd),
    .p_raddr(p_raddr),
    .i(i),
    .j(j),
    .result_value(result.result_value),
    .output_index(result.output_index),
    .last_output(result.last_output)
  );

endmodule
